>>> sv/fra_pkg.sv
// Shared widths, types and helpers of the fraction arithmetic reduce block.
package fra_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int NUM_W   = 2 * OPERAND_WIDTH + 1;
   localparam int DEN_W   = 2 * OPERAND_WIDTH;
   localparam int SHIFT_W = $clog2(NUM_W);
   localparam int CNT_W   = $clog2(NUM_W + 1);

   // Gcd as base << shift, where base is what is left after the common powers of two.
   typedef struct packed {
      logic [NUM_W-1:0]   base;
      logic [SHIFT_W-1:0] shift;
   } fra_gcd_res_type;

   // Magnitude of a two's complement value. The most negative code never occurs here.
   function automatic logic [NUM_W-1:0] fra_mag(input logic [NUM_W-1:0] x);
      logic [NUM_W-1:0] r;
      r = x[NUM_W-1] ? ((~x) + NUM_W'(1)) : x;
      return r;
   endfunction

   // Negate when neg is set.
   function automatic logic [NUM_W-1:0] fra_apply_sign(input logic [NUM_W-1:0] x,
                                                       input logic neg);
      logic [NUM_W-1:0] r;
      r = neg ? ((~x) + NUM_W'(1)) : x;
      return r;
   endfunction

endpackage

>>> sv/fra_gcd.sv
// Binary gcd unit: one shift or subtract step per cycle.
module fra_gcd (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [fra_pkg::NUM_W-1:0] a_mag,
   input  logic [fra_pkg::NUM_W-1:0] b_mag,
   output logic                      done,
   output fra_pkg::fra_gcd_res_type  result
);

   logic                        run_ff, run_in;
   logic                        done_ff, done_in;
   logic [fra_pkg::NUM_W-1:0]   a_ff, a_in;
   logic [fra_pkg::NUM_W-1:0]   b_ff, b_in;
   logic [fra_pkg::SHIFT_W-1:0] k_ff, k_in;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      a_in    = a_ff;
      b_in    = b_ff;
      k_in    = k_ff;
      if (start) begin
         run_in = 1'b1;
         k_in   = '0;
         // A zero operand makes the divisor one.
         if (a_mag == '0 || b_mag == '0) begin
            a_in = fra_pkg::NUM_W'(1);
            b_in = fra_pkg::NUM_W'(1);
         end else begin
            a_in = a_mag;
            b_in = b_mag;
         end
      end else if (run_ff) begin
         priority if (a_ff == b_ff) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + fra_pkg::SHIFT_W'(1);
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff > b_ff) begin
            a_in = a_ff - b_ff;
         end else begin
            b_in = b_ff - a_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      k_ff <= k_in;
   end

   assign done         = done_ff;
   assign result.base  = a_ff;
   assign result.shift = k_ff;

endmodule

>>> sv/fra_div.sv
// Restoring divider: one quotient bit per cycle, shared by both result fields.
module fra_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [fra_pkg::NUM_W-1:0] dividend,
   input  logic [fra_pkg::NUM_W-1:0] divisor,
   output logic                      done,
   output logic [fra_pkg::NUM_W-1:0] quotient
);

   logic                      run_ff, run_in;
   logic                      done_ff, done_in;
   logic [fra_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [fra_pkg::NUM_W-1:0] rem_ff, rem_in;
   logic [fra_pkg::NUM_W-1:0] quo_ff, quo_in;
   logic [fra_pkg::NUM_W-1:0] dvs_ff, dvs_in;
   logic [fra_pkg::NUM_W:0]   trial;
   logic [fra_pkg::NUM_W:0]   diff;
   logic                      fits;

   assign trial = {rem_ff, quo_ff[fra_pkg::NUM_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = fra_pkg::CNT_W'(fra_pkg::NUM_W);
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (run_ff) begin
         rem_in = fits ? diff[fra_pkg::NUM_W-1:0] : trial[fra_pkg::NUM_W-1:0];
         quo_in = {quo_ff[fra_pkg::NUM_W-2:0], fits};
         cnt_in = cnt_ff - fra_pkg::CNT_W'(1);
         if (cnt_ff == fra_pkg::CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> sv/fraction_arith_reduce_core.sv
// Top level: fraction add, subtract or multiply with gcd reduction under a small sequencer.
// Sequence: the multiply steps on one shared multiplier, the sum, then the binary gcd loop
//   (one step a cycle) and two divisions on one divider; the time taken per item is set
//   mostly by the gcd loop and the shared divider.
// Throughput: one item at a time; req_stall is high from acceptance until the result is
//   parked in the output register, which lets the next transfer in while it waits.
// Reset: synchronous; clears the sequencer and the output valid, no payload is cleared.
module fraction_arith_reduce_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [1:0]                               req_opcode,
   input  logic signed [fra_pkg::OPERAND_WIDTH-1:0] req_a_num,
   input  logic signed [fra_pkg::OPERAND_WIDTH-1:0] req_a_den,
   input  logic signed [fra_pkg::OPERAND_WIDTH-1:0] req_b_num,
   input  logic signed [fra_pkg::OPERAND_WIDTH-1:0] req_b_den,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [fra_pkg::NUM_W-1:0]         rsp_res_num,
   output logic signed [fra_pkg::DEN_W-1:0]         rsp_res_den
);

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b0000000001,
      ST_MUL     = 10'b0000000010,
      ST_SUM     = 10'b0000000100,
      ST_GCD_GO  = 10'b0000001000,
      ST_GCD     = 10'b0000010000,
      ST_DIVN_GO = 10'b0000100000,
      ST_DIVN    = 10'b0001000000,
      ST_DIVD_GO = 10'b0010000000,
      ST_DIVD    = 10'b0100000000,
      ST_FINISH  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // Captured operands.
   logic [1:0]                               op_ff;
   logic signed [fra_pkg::OPERAND_WIDTH-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic [1:0]                               mcnt_ff, mcnt_in;

   // Shared multiplier and its result registers.
   logic signed [fra_pkg::OPERAND_WIDTH-1:0] mul_a, mul_b;
   logic signed [fra_pkg::DEN_W-1:0]         mul_p;
   logic signed [fra_pkg::DEN_W-1:0]         den_ff, p1_ff, p2_ff;
   logic signed [fra_pkg::NUM_W-1:0]         num_ff, num_in;
   logic signed [fra_pkg::NUM_W-1:0]         p1_x, p2_x, den_x;

   // Reduction datapath.
   logic [fra_pkg::NUM_W-1:0]   num_mag, den_mag;
   logic                        gcd_start, gcd_done;
   fra_pkg::fra_gcd_res_type    gcd_res;
   logic [fra_pkg::NUM_W-1:0]   gbase_ff;
   logic [fra_pkg::SHIFT_W-1:0] gshift_ff;
   logic                        div_start, div_done;
   logic [fra_pkg::NUM_W-1:0]   div_dividend, div_quot;
   logic [fra_pkg::NUM_W-1:0]   qn_ff;

   // Output register.
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [fra_pkg::NUM_W-1:0]  res_num_ff;
   logic signed [fra_pkg::DEN_W-1:0]  res_den_ff;
   logic [fra_pkg::NUM_W-1:0]         den_signed;
   logic                              load_out;

   assign req_stall = (state_ff != ST_IDLE);

   // Multiplier operands: step 0 den, step 1 first cross term or a*b, step 2 second term.
   always_comb begin
      unique case (mcnt_ff)
         2'd0: begin
            mul_a = ad_ff;
            mul_b = bd_ff;
         end
         2'd1: begin
            mul_a = an_ff;
            mul_b = op_ff[1] ? bn_ff : bd_ff;
         end
         default: begin
            mul_a = bn_ff;
            mul_b = ad_ff;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   assign p1_x  = {p1_ff[fra_pkg::DEN_W-1], p1_ff};
   assign p2_x  = {p2_ff[fra_pkg::DEN_W-1], p2_ff};
   assign den_x = {den_ff[fra_pkg::DEN_W-1], den_ff};

   // Opcode high bit selects multiply; otherwise the low bit picks subtract.
   always_comb begin
      priority if (op_ff[1]) begin
         num_in = p1_x;
      end else if (op_ff[0]) begin
         num_in = p1_x - p2_x;
      end else begin
         num_in = p1_x + p2_x;
      end
   end

   assign num_mag = fra_pkg::fra_mag(num_ff);
   assign den_mag = fra_pkg::fra_mag(den_x);

   assign gcd_start = (state_ff == ST_GCD_GO);
   assign div_start = (state_ff == ST_DIVN_GO) || (state_ff == ST_DIVD_GO);

   // Both raw values are multiples of the gcd, so the power-of-two part drops by shift.
   assign div_dividend = (state_ff == ST_DIVD_GO) ? (den_mag >> gshift_ff)
                                                  : (num_mag >> gshift_ff);

   fra_gcd u_gcd (
      .clock  (clock),
      .reset  (reset),
      .start  (gcd_start),
      .a_mag  (num_mag),
      .b_mag  (den_mag),
      .done   (gcd_done),
      .result (gcd_res)
   );

   fra_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (gbase_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Park the finished result when the output register is free or being drained.
   assign load_out   = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign den_signed = fra_pkg::fra_apply_sign(div_quot, den_ff[fra_pkg::DEN_W-1]);

   always_comb begin
      state_in     = state_ff;
      mcnt_in      = mcnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            mcnt_in = 2'd0;
            if (req_valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            mcnt_in = mcnt_ff + 2'd1;
            if (mcnt_ff == 2'd2) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM:     state_in = ST_GCD_GO;
         ST_GCD_GO:  state_in = ST_GCD;
         ST_GCD: begin
            if (gcd_done) begin
               state_in = ST_DIVN_GO;
            end
         end
         ST_DIVN_GO: state_in = ST_DIVN;
         ST_DIVN: begin
            if (div_done) begin
               state_in = ST_DIVD_GO;
            end
         end
         ST_DIVD_GO: state_in = ST_DIVD;
         ST_DIVD: begin
            if (div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (load_out) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mcnt_ff <= mcnt_in;
      // Capture the operands on the accepting edge.
      if (state_ff == ST_IDLE && req_valid) begin
         op_ff <= req_opcode;
         an_ff <= req_a_num;
         ad_ff <= req_a_den;
         bn_ff <= req_b_num;
         bd_ff <= req_b_den;
      end
      if (state_ff == ST_MUL) begin
         unique case (mcnt_ff)
            2'd0:    den_ff <= mul_p;
            2'd1:    p1_ff  <= mul_p;
            default: p2_ff  <= mul_p;
         endcase
      end
      if (state_ff == ST_SUM) begin
         num_ff <= num_in;
      end
      if (state_ff == ST_GCD && gcd_done) begin
         gbase_ff  <= gcd_res.base;
         gshift_ff <= gcd_res.shift;
      end
      if (state_ff == ST_DIVN && div_done) begin
         qn_ff <= div_quot;
      end
      // Load the payload only when it is parked; the divider holds the denominator
      // quotient until then, so a stalled result never changes under the receiver.
      if (load_out) begin
         res_den_ff <= den_signed[fra_pkg::DEN_W-1:0];
         res_num_ff <= fra_pkg::fra_apply_sign(qn_ff, num_ff[fra_pkg::NUM_W-1]);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_res_num = res_num_ff;
   assign rsp_res_den = res_den_ff;

   // The gcd unit only finishes while the sequencer waits on it.
   a_gcd_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      gcd_done |-> state_ff == ST_GCD)
      else $error("gcd done outside its wait state");

   // The divider only finishes during one of the two division waits.
   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVN || state_ff == ST_DIVD))
      else $error("divider done outside a division wait state");

   // An accepted transfer starts the multiply sequence at the first step.
   a_accept_starts_mul: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_MUL && mcnt_ff == 2'd0))
      else $error("accepted transfer did not start the multiply steps");

   // The divisor used for a result is never zero.
   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> gbase_ff != '0)
      else $error("result produced with a zero divisor");

endmodule

>>> tb/sv/tb_fraction_arith_reduce_core.sv
// Testbench for fraction_arith_reduce_core: queued stimulus, random idling, predicted results.
module tb_fraction_arith_reduce_core;

   localparam int OPW         = fra_pkg::OPERAND_WIDTH;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_WAIT  = 250;   // longer than the slowest gcd and two divisions
   localparam int RANDOM_OPS  = 850;

   // Opcode three decodes on its high bit and behaves as multiply.
   typedef enum logic [1:0] {
      OP_ADD     = 2'd0,
      OP_SUB     = 2'd1,
      OP_MUL     = 2'd2,
      OP_MUL_ALT = 2'd3
   } frac_op_type;

   typedef struct {
      frac_op_type             opcode;
      logic signed [OPW-1:0]   a_num;
      logic signed [OPW-1:0]   a_den;
      logic signed [OPW-1:0]   b_num;
      logic signed [OPW-1:0]   b_den;
      int unsigned             gap;     // idle cycles before this transfer
      bit                      drain;   // hold until every result is back
      bit                      quiet;   // no receiver stall after its result
   } frac_req_type;

   typedef struct {
      logic signed [fra_pkg::NUM_W-1:0] res_num;
      logic signed [fra_pkg::DEN_W-1:0] res_den;
      bit                               quiet;
   } frac_res_type;

   logic                             clock;
   logic                             reset       = 1'b1;
   logic                             req_valid   = 1'b0;
   logic                             req_stall;
   logic [1:0]                       req_opcode  = '0;
   logic signed [OPW-1:0]            req_a_num   = '0;
   logic signed [OPW-1:0]            req_a_den   = '0;
   logic signed [OPW-1:0]            req_b_num   = '0;
   logic signed [OPW-1:0]            req_b_den   = '0;
   logic                             rsp_valid;
   logic                             rsp_stall   = 1'b0;
   logic signed [fra_pkg::NUM_W-1:0] rsp_res_num;
   logic signed [fra_pkg::DEN_W-1:0] rsp_res_den;

   frac_req_type fraction_op_q[$];   // items still to be sent
   frac_res_type reduced_q[$];       // reduced fractions still to be received
   frac_req_type on_bus;
   int unsigned  stall_left  = 0;
   int unsigned  cycle_count = 0;
   int unsigned  error_count = 0;

   fraction_arith_reduce_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_opcode  (req_opcode),
      .req_a_num   (req_a_num),
      .req_a_den   (req_a_den),
      .req_b_num   (req_b_num),
      .req_b_den   (req_b_den),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_res_num (rsp_res_num),
      .rsp_res_den (rsp_res_den)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Form the raw cross product, then divide both parts by the gcd of their magnitudes.
   // A zero on either side makes the divisor one; exact division keeps the signs.
   function automatic frac_res_type reduce_fraction(input frac_req_type r);
      longint       an, ad, bn, bd, num, den, x, y, t;
      frac_res_type e;
      an  = longint'(r.a_num);
      ad  = longint'(r.a_den);
      bn  = longint'(r.b_num);
      bd  = longint'(r.b_den);
      den = ad * bd;
      if (r.opcode[1]) begin
         num = an * bn;
      end else if (r.opcode == OP_SUB) begin
         num = an * bd - bn * ad;
      end else begin
         num = an * bd + bn * ad;
      end
      x = (num < 0) ? -num : num;
      y = (den < 0) ? -den : den;
      if (x == 0 || y == 0) begin
         x = 1;
      end else begin
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
      end
      e.res_num = fra_pkg::NUM_W'(num / x);
      e.res_den = fra_pkg::DEN_W'(den / x);
      e.quiet   = r.quiet;
      return e;
   endfunction

   // Mix full-range codes with small values, corners and powers of two so that
   // common factors and long runs of shared twos show up often.
   function automatic logic signed [OPW-1:0] pick_operand();
      int v;
      case ($urandom_range(0, 5))
         0, 1: v = int'($urandom_range(0, (1 << OPW) - 1));
         2:    v = int'($urandom_range(0, 40)) - 20;
         3: begin
            case ($urandom_range(0, 5))
               0:       v = 0;
               1:       v = 1;
               2:       v = -1;
               3:       v = (1 << (OPW - 1)) - 1;
               4:       v = -(1 << (OPW - 1));
               default: v = 2;
            endcase
         end
         4: begin
            v = int'($urandom_range(1, 15)) << $urandom_range(0, OPW - 5);
            if ($urandom_range(0, 1) != 0) v = -v;
         end
         default: v = (int'($urandom_range(0, 60)) - 30) * 6;
      endcase
      return OPW'(v);
   endfunction

   task automatic queue_op(input frac_op_type op, input int an, input int ad, input int bn,
                           input int bd, input int unsigned gap, input bit drain,
                           input bit quiet);
      frac_req_type r;
      r.opcode = op;
      r.a_num  = OPW'(an);
      r.a_den  = OPW'(ad);
      r.b_num  = OPW'(bn);
      r.b_den  = OPW'(bd);
      r.gap    = gap;
      r.drain  = drain;
      r.quiet  = quiet;
      fraction_op_q.push_back(r);
   endtask

   // Driver: record the transfer that completes at this edge, then either hold,
   // count down the next item's gap, wait out a drain, or present the next item.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            reduced_q.push_back(reduce_fraction(on_bus));
         end
         if (!req_valid || !req_stall) begin
            if (fraction_op_q.size() != 0 && fraction_op_q[0].gap != 0) begin
               fraction_op_q[0].gap = fraction_op_q[0].gap - 1;
               req_valid <= 1'b0;
            end else if (fraction_op_q.size() != 0 &&
                         !(fraction_op_q[0].drain && reduced_q.size() != 0)) begin
               on_bus = fraction_op_q.pop_front();
               req_valid  <= 1'b1;
               req_opcode <= on_bus.opcode;
               req_a_num  <= on_bus.a_num;
               req_a_den  <= on_bus.a_den;
               req_b_num  <= on_bus.b_num;
               req_b_den  <= on_bus.b_den;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result transfer against the oldest prediction, then
   // draw how long to stall before taking the next one.
   always @(posedge clock) begin
      frac_res_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (reduced_q.size() == 0) begin
               $error("rsp: result transfer with nothing pending, num %0d den %0d",
                      rsp_res_num, rsp_res_den);
               error_count++;
               stall_left = $urandom_range(0, 4);
            end else begin
               e = reduced_q.pop_front();
               if (rsp_res_num !== e.res_num) begin
                  $error("res_num: expected %0d, got %0d", e.res_num, rsp_res_num);
                  error_count++;
               end
               if (rsp_res_den !== e.res_den) begin
                  $error("res_den: expected %0d, got %0d", e.res_den, rsp_res_den);
                  error_count++;
               end
               stall_left = e.quiet ? 0 : $urandom_range(0, 4);
            end
         end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** fraction_arith_reduce_core: FAILED **");
         $finish;
      end
   end

   initial begin
      frac_req_type r;
      bit           quiet;

      // Directed: simple cases first with no idling, then the corners.
      queue_op(OP_ADD,      1,  2,  1,  3, 0, 0, 1);
      queue_op(OP_SUB,      1,  2,  1,  2, 0, 0, 1);   // zero numerator stays unreduced
      queue_op(OP_MUL,      0,  1,  5,  6, 0, 0, 1);   // 0/6 stays 0/6
      queue_op(OP_MUL_ALT,  3,  4,  2,  9, 0, 0, 1);   // opcode three multiplies
      queue_op(OP_ADD,      1,  0,  1,  5, 0, 0, 1);   // zero denominator passes through
      queue_op(OP_SUB,      1, -2,  1,  3, 0, 0, 1);   // negative denominator kept
      queue_op(OP_MUL,     -3,  4,  2, -6, 0, 0, 1);
      queue_op(OP_ADD,  32767,  1, 32767,  1, 0, 0, 1);
      queue_op(OP_ADD, -32768,  1, -32768, 1, 1, 0, 0);
      queue_op(OP_MUL, -32768, -32768, -32768, -32768, 2, 0, 0);
      queue_op(OP_ADD, -32768, -32768, -32768, -32768, 0, 0, 0);
      queue_op(OP_SUB,  32767, -32768, -32768, 32767, 3, 0, 0);
      queue_op(OP_MUL,  32767,  32767, -32768, -32768, 0, 0, 0);
      queue_op(OP_ADD,      0,  0,  0,  0, 4, 0, 0);
      queue_op(OP_SUB,     -1, -1, -1, -1, 0, 0, 0);
      queue_op(OP_MUL,     -1,  1, -1,  1, 1, 0, 0);
      queue_op(OP_ADD,      7, 12,  5, -18, 0, 0, 0);
      queue_op(OP_SUB,  32767, -1, -32768, 1, 2, 0, 0);
      queue_op(OP_MUL,      0,  0, 32767, -32768, 0, 0, 0);
      queue_op(OP_ADD, -32768, 32767, 32767, -32768, 0, 0, 0);
      queue_op(OP_MUL_ALT, -32768, -1, -32768, -1, 0, 0, 0);

      // Random: a no-idle stretch in the middle, and a full drain every 150 items.
      for (int i = 0; i < RANDOM_OPS; i++) begin
         quiet    = (i >= 300 && i < 400);
         r.opcode = frac_op_type'($urandom_range(0, 3));
         r.a_num  = pick_operand();
         r.a_den  = pick_operand();
         r.b_num  = pick_operand();
         r.b_den  = pick_operand();
         r.gap    = quiet ? 0 : $urandom_range(0, 4);
         r.drain  = (i % 150 == 0);
         r.quiet  = quiet;
         fraction_op_q.push_back(r);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last transfer out, then for every result.
      while (fraction_op_q.size() != 0 || req_valid || reduced_q.size() != 0) begin
         @(posedge clock);
      end
      // Leave room for any stray result to show up.
      repeat (DRAIN_WAIT) @(posedge clock);

      if (error_count == 0) begin
         $display("** fraction_arith_reduce_core: PASSED **");
      end else begin
         $display("** fraction_arith_reduce_core: FAILED **");
      end
      $finish;
   end

endmodule

>>> files.f
sv/fra_pkg.sv
sv/fra_gcd.sv
sv/fra_div.sv
sv/fraction_arith_reduce_core.sv
tb/sv/tb_fraction_arith_reduce_core.sv
